[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bmpu_pkg.sv]
// Types and constants of the BMP raster pixel unpacker.
package bmpu_pkg;

    localparam int MAX_DIM_DEF       = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    // Configuration register widths
    localparam int DIM_CFG_W   = 13;
    localparam int DEPTH_CFG_W = 3;
    localparam int COLORS_W    = 9;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLORS = 2'd3;

    // Opcodes
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_RASTER  = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    // Depth codes
    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_2  = 3'd1;
    localparam logic [2:0] DEPTH_4  = 3'd2;
    localparam logic [2:0] DEPTH_8  = 3'd3;
    localparam logic [2:0] DEPTH_24 = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  raster_byte;
        logic [7:0]  palette_index;
        logic [31:0] palette_color;
    } item_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] pixel_color;
        logic        last_of_byte;
        logic        image_end;
    } pixel_t;

endpackage

[src/bmpu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bmpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write to one entry in a cycle returns the old word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bmp_raster_pixel_unpacker_top.sv]
// Top level of the BMP raster pixel unpacker.
// A raster byte accepted into the byte register is expanded into palette reads; each pixel is
// registered in the output stage beside its palette word. Throughput: one pixel per cycle while
// the output is not stalled, set by the expander issuing one palette read per cycle on the
// palette RAM's single read port. Palette, start and ignored items do not set the expander busy
// and are accepted back to back. Reset clears position, flags and configuration registers to
// their reset values; palette words are unknown until loaded, and there is no clearing pass.
module bmp_raster_pixel_unpacker_top
    import bmpu_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    // result pixels
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output pixel_t                pixel,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "assert_macros.svh"

    // Largest usable dimension: the clamp limit, bounded by the register width.
    localparam int DIM_REG_MAX = (1 << DIM_CFG_W) - 1;
    localparam int DIM_CAP     = (MAX_DIM < DIM_REG_MAX) ? MAX_DIM : DIM_REG_MAX;
    localparam int POS_W       = $clog2(DIM_CAP + 1);
    localparam int PAL_AW      = $clog2(PALETTE_DEPTH);

    // Pixel on its way through the palette read
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             rgb;       // direct 24-bit color
        logic             use_pal;   // valid palette index
        logic             clr_prev;  // first pixel after a start: previous color is zero
        logic [23:0]      direct;
        logic             last;
        logic             end_img;
    } meta_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DIM_CFG_W-1:0]   width_reg;
    logic [DIM_CFG_W-1:0]   height_reg;
    logic [DEPTH_CFG_W-1:0] depth_reg;
    logic [COLORS_W-1:0]    colors_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_CFG_W'(1);
            height_reg <= DIM_CFG_W'(1);
            depth_reg  <= DEPTH_8;
            colors_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_DEPTH:  depth_reg  <= cfg_data[DEPTH_CFG_W-1:0];
                CFG_COLORS: colors_reg <= cfg_data[COLORS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Clamped dimensions: zero acts as one, above the limit acts as the limit
    logic [POS_W-1:0] w_clamp;
    logic [POS_W-1:0] h_clamp;

    always_comb
    begin
        if (width_reg == '0)
            w_clamp = POS_W'(1);
        else if (width_reg > DIM_CFG_W'(DIM_CAP))
            w_clamp = POS_W'(DIM_CAP);
        else
            w_clamp = POS_W'(width_reg);

        if (height_reg == '0)
            h_clamp = POS_W'(1);
        else if (height_reg > DIM_CFG_W'(DIM_CAP))
            h_clamp = POS_W'(DIM_CAP);
        else
            h_clamp = POS_W'(height_reg);
    end

    // Depth decode; unused codes behave as 8 bits per pixel
    logic       is_low;
    logic       is_rgb;
    logic [3:0] bpp;
    logic [7:0] pix_mask;

    always_comb
    begin
        is_low   = 1'b0;
        is_rgb   = 1'b0;
        bpp      = 4'd8;
        pix_mask = 8'hFF;
        case (depth_reg)
            DEPTH_1:
            begin
                is_low   = 1'b1;
                bpp      = 4'd1;
                pix_mask = 8'h01;
            end
            DEPTH_2:
            begin
                is_low   = 1'b1;
                bpp      = 4'd2;
                pix_mask = 8'h03;
            end
            DEPTH_4:
            begin
                is_low   = 1'b1;
                bpp      = 4'd4;
                pix_mask = 8'h0F;
            end
            DEPTH_24:
            begin
                is_rgb = 1'b1;
                bpp    = 4'd8;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Position state and byte expander
    // ---------------------------------------------------------------
    logic             busy_reg,    busy_next;
    logic [7:0]       byte_reg,    byte_next;
    logic [2:0]       bitpos_reg,  bitpos_next;
    logic [POS_W-1:0] col_reg,     col_next;
    logic [POS_W-1:0] row_reg,     row_next;
    logic [1:0]       rbc_reg,     rbc_next;      // row byte count, modulo four
    logic [1:0]       phase_reg,   phase_next;    // 24-bit byte phase
    logic [15:0]      partial_reg, partial_next;
    logic             fin_reg,     fin_next;      // image finished
    logic             clrp_reg,    clrp_next;     // previous color cleared by start

    logic             pix_valid_reg;
    meta_t            meta_reg;
    logic [31:0]      prev_reg;

    logic             pix_free;
    logic             step;
    logic             active;
    logic             emit;
    logic             done;
    logic             issue;
    logic [POS_W:0]   col_inc;
    logic             end_pix;
    logic [7:0]       idx;
    logic             use_pal;
    logic [POS_W:0]   col_after;
    logic [1:0]       rbc_inc;
    logic             item_acc;
    meta_t            meta_new;

    assign pix_free = !pix_valid_reg || !pixel_stall;
    assign step     = busy_reg && pix_free;
    assign active   = !fin_reg && (col_reg < w_clamp);
    assign col_inc  = {1'b0, col_reg} + (POS_W+1)'(1);
    assign end_pix  = (row_reg == '0) && (col_inc == {1'b0, w_clamp});
    assign emit     = active && (!is_rgb || phase_reg[1]);
    assign done     = !emit || !is_low || ({1'b0, bitpos_reg} < bpp)
                      || (col_inc >= {1'b0, w_clamp});
    assign issue    = step && emit;
    assign item_acc = item_valid && !item_stall;

    // next item waits while the current byte is busy and its final step is not taken
    assign item_stall = busy_reg && !(step && done);

    assign idx     = is_low ? ((byte_reg >> bitpos_reg) & pix_mask) : byte_reg;
    assign use_pal = !is_rgb && ({1'b0, idx} < colors_reg)
                     && ({1'b0, idx} < COLORS_W'(PALETTE_DEPTH));

    assign col_after = emit ? col_inc : {1'b0, col_reg};
    assign rbc_inc   = rbc_reg + 2'd1;

    always_comb
    begin
        busy_next    = busy_reg;
        byte_next    = byte_reg;
        bitpos_next  = bitpos_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        rbc_next     = rbc_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        fin_next     = fin_reg;
        clrp_next    = clrp_reg;

        if (step)
        begin
            if (emit)
            begin
                col_next  = POS_W'(col_inc);
                clrp_next = 1'b0;
                if (end_pix)
                    fin_next = 1'b1;
            end
            if (done)
            begin
                busy_next = 1'b0;
                if (!fin_reg)
                begin
                    if (active && is_rgb)
                    begin
                        case (phase_reg)
                            2'd0:
                            begin
                                partial_next = {8'h00, byte_reg};
                                phase_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                partial_next = {byte_reg, partial_reg[7:0]};
                                phase_next   = 2'd2;
                            end
                            default:
                            begin
                                partial_next = '0;
                                phase_next   = 2'd0;
                            end
                        endcase
                    end
                    rbc_next = rbc_inc;
                    // row ends once its pixels are out and the bytes reach a word boundary
                    if ((col_after >= {1'b0, w_clamp}) && (rbc_inc == 2'd0)
                        && !(emit && end_pix))
                    begin
                        col_next     = '0;
                        rbc_next     = '0;
                        phase_next   = 2'd0;
                        partial_next = '0;
                        if (row_reg == '0)
                            fin_next = 1'b1;
                        else
                            row_next = row_reg - POS_W'(1);
                    end
                end
            end
            else
            begin
                bitpos_next = 3'({1'b0, bitpos_reg} - bpp);
            end
        end

        if (item_acc)
        begin
            case (item.opcode)
                OP_RASTER:
                begin
                    busy_next   = 1'b1;
                    byte_next   = item.raster_byte;
                    bitpos_next = 3'(4'd8 - bpp);
                end
                OP_START:
                begin
                    col_next     = '0;
                    row_next     = h_clamp - POS_W'(1);
                    rbc_next     = '0;
                    phase_next   = 2'd0;
                    partial_next = '0;
                    fin_next     = 1'b0;
                    clrp_next    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            rbc_reg     <= '0;
            phase_reg   <= '0;
            partial_reg <= '0;
            fin_reg     <= 1'b0;
            clrp_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            rbc_reg     <= rbc_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            fin_reg     <= fin_next;
            clrp_reg    <= clrp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bitpos_reg <= bitpos_next;
    end

    // ---------------------------------------------------------------
    // Palette memory
    // ---------------------------------------------------------------
    logic              pal_we;
    logic [31:0]       pal_rdata;

    assign pal_we = item_acc && (item.opcode == OP_PALETTE)
                    && ({1'b0, item.palette_index} < COLORS_W'(PALETTE_DEPTH));

    bmpu_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (item.palette_index[PAL_AW-1:0]),
        .wdata (item.palette_color),
        .re    (issue),
        .raddr (idx[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

    // ---------------------------------------------------------------
    // Output stage: pixel meta beside the registered palette word
    // ---------------------------------------------------------------
    always_comb
    begin
        meta_new          = '0;
        meta_new.x        = col_reg;
        meta_new.y        = row_reg;
        meta_new.rgb      = is_rgb;
        meta_new.use_pal  = use_pal;
        meta_new.clr_prev = clrp_reg;
        meta_new.direct   = {byte_reg, partial_reg};
        meta_new.last     = done;
        meta_new.end_img  = end_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (pix_free)
            pix_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            meta_reg <= meta_new;
    end

    logic [31:0] out_color;

    // an invalid index repeats the color of the pixel before, or gives zero for the first pixel after a start
    always_comb
    begin
        if (meta_reg.rgb)
            out_color = {8'h00, meta_reg.direct};
        else if (meta_reg.use_pal)
            out_color = pal_rdata;
        else if (meta_reg.clr_prev)
            out_color = '0;
        else
            out_color = prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= '0;
        else if (pixel_valid && !pixel_stall)
            prev_reg <= out_color;
    end

    assign pixel_valid        = pix_valid_reg;
    assign pixel.pixel_x      = 12'(meta_reg.x);
    assign pixel.pixel_y      = 12'(meta_reg.y);
    assign pixel.pixel_color  = out_color;
    assign pixel.last_of_byte = meta_reg.last;
    assign pixel.image_end    = meta_reg.end_img;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic pix_held;

    assign pix_held = pix_valid_reg && pixel_stall;

    `ASSERT_NEXT(a_read_lands, clk, rst_n, issue, pix_valid_reg, "palette read without pixel")
    `ASSERT_NEXT(a_rdata_held, clk, rst_n, pix_held, $stable(pal_rdata), "palette word lost")
    `ASSERT_NEXT(a_byte_keeps, clk, rst_n, step && !done, busy_reg, "byte dropped early")
    `ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, col_reg <= POS_W'(DIM_CAP), "column beyond limit")

endmodule
